>>> hdl/wna_pkg.sv
package wna_pkg;

   localparam int MAX_FEAT_DIM_DEF = 64;

   localparam int DIM_W     = 7;
   localparam int IDX_OUT_W = 6;
   localparam int VALUE_W   = 24;
   localparam int WEIGHT_W  = 16;
   localparam int PROD_W    = VALUE_W + WEIGHT_W;
   localparam int ACC_W     = 48;
   localparam int SUM_W     = 24;
   localparam int FRAC_DROP = 14;

   localparam logic [DIM_W-1:0] FEAT_DIM_RST = 7'd64;

   localparam logic OP_SELF = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   localparam logic [ACC_W-1:0] ACC_MAX    = 48'h7FFF_FFFF_FFFF;
   localparam logic [ACC_W-1:0] ACC_MIN    = 48'h8000_0000_0000;
   localparam logic [SUM_W-1:0] SUM_MAX    = 24'h7F_FFFF;
   localparam logic [SUM_W-1:0] SUM_MIN    = 24'h80_0000;
   localparam logic [ACC_W:0]   ROUND_BIAS = 49'd8192;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [IDX_OUT_W-1:0]      out_index;
      logic signed [SUM_W-1:0]   sum;
      logic                      saturated;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
   } fifo_stat_type;

endpackage

>>> hdl/wna_if.sv
interface wna_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   op;
   logic [wna_pkg::IDX_OUT_W-1:0]          feat_index;
   logic signed [wna_pkg::VALUE_W-1:0]     value;
   logic signed [wna_pkg::WEIGHT_W-1:0]    weight;
   logic                                   end_vertex;

   modport source (output valid, op, feat_index, value, weight, end_vertex, input ready);
   modport sink   (input valid, op, feat_index, value, weight, end_vertex, output ready);
endinterface

interface wna_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [wna_pkg::IDX_OUT_W-1:0]          out_index;
   logic signed [wna_pkg::SUM_W-1:0]       sum;
   logic                                   saturated;
   logic                                   last;

   modport source (output valid, out_index, sum, saturated, last, input ready);
   modport sink   (input valid, out_index, sum, saturated, last, output ready);
endinterface

>>> hdl/wna_acc_mem.sv
module wna_acc_mem #(
   parameter int ADDR_W = 7
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [wna_pkg::ACC_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]          rd_a_addr,
   output logic [wna_pkg::ACC_W-1:0]  rd_a_data,
   input  logic [ADDR_W-1:0]          rd_b_addr,
   output logic [wna_pkg::ACC_W-1:0]  rd_b_data
);

   logic [wna_pkg::ACC_W-1:0] mem [2**ADDR_W];

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

>>> hdl/wna_out_fifo.sv
module wna_out_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_vld,
   input  wna_pkg::rsp_type        push_data,
   output wna_pkg::fifo_stat_type  stat,
   wna_rsp_if.source               rsp_if
);

   wna_pkg::rsp_type                 slot_ff [wna_pkg::FIFO_DEPTH];
   logic [wna_pkg::FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [wna_pkg::FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [wna_pkg::FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                             pop;
   wna_pkg::rsp_type                 head;

   assign pop  = rsp_if.valid && rsp_if.ready;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_vld ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_vld && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_vld) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_vld) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign stat.count       = count_ff;
   assign rsp_if.valid     = (count_ff != '0);
   assign rsp_if.out_index = head.out_index;
   assign rsp_if.sum       = head.sum;
   assign rsp_if.saturated = head.saturated;
   assign rsp_if.last      = head.last;

endmodule

>>> hdl/weighted_neighbor_aggregation.sv
// Weighted neighbour aggregation for one graph vertex, one feature element per transaction.
// req_if carries op (self loads accumulator j with value*weight, edge adds value*weight),
// feat_index, value (Q8.16), weight (Q2.14) and end_vertex. A transaction flagged
// end_vertex is applied first, then a snapshot of the first feat_dim accumulators is taken.
// From that transaction on, every accepted transaction releases the next snapshot element
// on rsp_if (out_index, sum rounded to Q8.16 with clip flag, last on the final element).
// A new end_vertex during a drain restarts it from element zero with a fresh snapshot.
// csr_we/csr_wdata write feat_dim; write it only while the block is idle.
// Throughput: one transaction per cycle while req_if.ready is high. The accumulators sit in
// one two-read, one-write memory holding two copies of each entry, so a snapshot copies
// nothing: the drain reads the frozen copy while live updates go to the other one.
// A result passes the stage-1 and stage-2 registers, is then pushed into the output queue
// and can be taken on rsp_if once it is queued.
// When the receiver stalls, the four-entry output queue fills and req_if.ready drops once
// queued plus in-flight results reach its depth; no result is lost.
// Reset: feat_dim returns to 64, no drain is pending, the output queue empties.
// Accumulator contents are undefined until written; no clearing pass is run.
module weighted_neighbor_aggregation #(
   parameter int MAX_FEAT_DIM = wna_pkg::MAX_FEAT_DIM_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [wna_pkg::DIM_W-1:0]  csr_wdata,
   wna_req_if.sink                    req_if,
   wna_rsp_if.source                  rsp_if
);

   localparam int IDX_W   = (MAX_FEAT_DIM > 1) ? $clog2(MAX_FEAT_DIM) : 1;
   localparam int LEN_W   = $clog2(MAX_FEAT_DIM + 1);
   localparam int CW      = (LEN_W > wna_pkg::DIM_W) ? LEN_W : wna_pkg::DIM_W;
   localparam int ADDR_W  = IDX_W + 1;
   localparam int ACC_W   = wna_pkg::ACC_W;
   localparam int PROD_W  = wna_pkg::PROD_W;
   localparam int SUM_W   = wna_pkg::SUM_W;
   localparam int SHIFT_W = ACC_W + 1 - wna_pkg::FRAC_DROP;
   localparam int CNT_W   = wna_pkg::FIFO_CNT_W;

   // configuration and drain bookkeeping
   logic [wna_pkg::DIM_W-1:0]  feat_dim_ff, feat_dim_in;
   logic [MAX_FEAT_DIM-1:0]    cur_ff, cur_in;     // copy holding the live value
   logic [MAX_FEAT_DIM-1:0]    snap_ff, snap_in;   // copy frozen by the last snapshot
   logic [IDX_W-1:0]           pos_ff, pos_in;
   logic [LEN_W-1:0]           len_ff, len_in;

   // stage 1: read-modify-write
   logic                       s1_wr_ff, s1_res_ff;
   logic                       s1_op_ff, s1_last_ff;
   logic [ADDR_W-1:0]          s1_addr_ff, s1_daddr_ff, s1_raddr_ff;
   logic signed [PROD_W-1:0]   s1_prod_ff;
   logic [wna_pkg::IDX_OUT_W-1:0] s1_oidx_ff;

   // last write, for forwarding past the read-first memory
   logic                       lw_vld_ff;
   logic [ADDR_W-1:0]          lw_addr_ff;
   logic [ACC_W-1:0]           lw_data_ff;

   // stage 2: rounding
   logic                       s2_vld_ff;
   logic [ACC_W-1:0]           s2_acc_ff;
   logic [wna_pkg::IDX_OUT_W-1:0] s2_oidx_ff;
   logic                       s2_last_ff;

   logic                       accept;
   logic [CW-1:0]              fd_w, max_w, eff_w, j_w, pos_w;
   logic [LEN_W-1:0]           eff_len, len_n, pos_inc, pos_ext;
   logic [IDX_W-1:0]           j_idx, pos_n;
   logic                       in_range, wsel, emit, is_last;
   logic [MAX_FEAT_DIM-1:0]    cur_n, snap_n;
   logic signed [PROD_W-1:0]   prod;
   logic [ADDR_W-1:0]          live_raddr, drain_raddr;

   logic [ACC_W-1:0]           rd_a_data, rd_b_data;
   logic [ACC_W-1:0]           live_old, acc_sat, new_acc, drain_val;
   logic [ACC_W:0]             sum_wide;

   logic [ACC_W:0]             biased;
   logic [SHIFT_W-1:0]         shifted;
   logic [SHIFT_W-SUM_W:0]     upper;
   logic                       fits;
   wna_pkg::rsp_type           push_data;
   wna_pkg::fifo_stat_type     fifo_stat;
   logic [CNT_W-1:0]           credit_used;

   // Hold back input once queued and in-flight results would overrun the queue.
   assign credit_used  = fifo_stat.count + CNT_W'(s1_res_ff) + CNT_W'(s2_vld_ff);
   assign req_if.ready = (credit_used < CNT_W'(wna_pkg::FIFO_DEPTH));
   assign accept       = req_if.valid && req_if.ready;

   assign feat_dim_in = csr_we ? csr_wdata : feat_dim_ff;

   // Accept stage: index check, copy selection, drain step.
   always_comb begin
      fd_w    = CW'(feat_dim_ff);
      max_w   = CW'(MAX_FEAT_DIM);
      eff_w   = (fd_w == '0) ? CW'(1) : ((fd_w > max_w) ? max_w : fd_w);
      eff_len = eff_w[LEN_W-1:0];

      j_w      = CW'(req_if.feat_index);
      in_range = (j_w < eff_w);
      j_idx    = j_w[IDX_W-1:0];

      // live writes always land in the copy the snapshot does not own
      wsel  = ~snap_ff[j_idx];
      cur_n = cur_ff;
      if (accept && in_range) begin
         cur_n[j_idx] = wsel;
      end
      snap_n = (accept && req_if.end_vertex) ? cur_n : snap_ff;

      len_n   = req_if.end_vertex ? eff_len : len_ff;
      pos_n   = req_if.end_vertex ? '0 : pos_ff;
      emit    = (len_n != '0);
      pos_inc = LEN_W'(pos_n) + 1'b1;
      is_last = (pos_inc == len_n);
      pos_w   = CW'(pos_n);

      cur_in  = cur_n;
      snap_in = snap_n;
      pos_in  = pos_ff;
      len_in  = len_ff;
      if (accept && emit) begin
         pos_in = is_last ? '0 : pos_inc[IDX_W-1:0];
         len_in = is_last ? '0 : len_n;
      end

      live_raddr  = {cur_ff[j_idx], j_idx};
      drain_raddr = {snap_n[pos_n], pos_n};
   end

   assign prod = req_if.value * req_if.weight;

   always_ff @(posedge clock) begin
      if (reset) begin
         feat_dim_ff <= wna_pkg::FEAT_DIM_RST;
         cur_ff      <= '0;
         snap_ff     <= '0;
         pos_ff      <= '0;
         len_ff      <= '0;
         s1_wr_ff    <= 1'b0;
         s1_res_ff   <= 1'b0;
         lw_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
      end else begin
         feat_dim_ff <= feat_dim_in;
         cur_ff      <= cur_in;
         snap_ff     <= snap_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         s1_wr_ff    <= accept && in_range;
         s1_res_ff   <= accept && emit;
         lw_vld_ff   <= s1_wr_ff;
         s2_vld_ff   <= s1_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= req_if.op;
      s1_addr_ff  <= {wsel, j_idx};
      s1_raddr_ff <= live_raddr;
      s1_daddr_ff <= drain_raddr;
      s1_prod_ff  <= prod;
      s1_last_ff  <= is_last;
      s1_oidx_ff  <= pos_w[wna_pkg::IDX_OUT_W-1:0];
      lw_addr_ff  <= s1_addr_ff;
      lw_data_ff  <= new_acc;
      s2_acc_ff   <= drain_val;
      s2_oidx_ff  <= s1_oidx_ff;
      s2_last_ff  <= s1_last_ff;
   end

   wna_acc_mem #(
      .ADDR_W (ADDR_W)
   ) u_acc_mem (
      .clock     (clock),
      .wr_en     (s1_wr_ff),
      .wr_addr   (s1_addr_ff),
      .wr_data   (new_acc),
      .rd_a_addr (live_raddr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (drain_raddr),
      .rd_b_data (rd_b_data)
   );

   // Stage 1: merge the previous write, load (self) or accumulate with saturation (edge), forward to the drain.
   // The live value may have been read from the other copy than the one written back,
   // so match the previous write against the address actually read.
   always_comb begin
      live_old = (lw_vld_ff && (lw_addr_ff == s1_raddr_ff)) ? lw_data_ff : rd_a_data;
      sum_wide = {live_old[ACC_W-1], live_old}
               + {{(ACC_W + 1 - PROD_W){s1_prod_ff[PROD_W-1]}}, s1_prod_ff};
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         acc_sat = sum_wide[ACC_W] ? wna_pkg::ACC_MIN : wna_pkg::ACC_MAX;
      end else begin
         acc_sat = sum_wide[ACC_W-1:0];
      end
      new_acc = (s1_op_ff == wna_pkg::OP_SELF)
              ? {{(ACC_W - PROD_W){s1_prod_ff[PROD_W-1]}}, s1_prod_ff} : acc_sat;

      if (s1_wr_ff && (s1_addr_ff == s1_daddr_ff)) begin
         drain_val = new_acc;
      end else if (lw_vld_ff && (lw_addr_ff == s1_daddr_ff)) begin
         drain_val = lw_data_ff;
      end else begin
         drain_val = rd_b_data;
      end
   end

   // Stage 2: round half up to Q8.16 and clip.
   always_comb begin
      biased  = {s2_acc_ff[ACC_W-1], s2_acc_ff} + wna_pkg::ROUND_BIAS;
      shifted = biased[ACC_W:wna_pkg::FRAC_DROP];
      upper   = shifted[SHIFT_W-1:SUM_W-1];
      fits    = (upper == '0) || (upper == '1);

      push_data.out_index = s2_oidx_ff;
      push_data.last      = s2_last_ff;
      push_data.saturated = !fits;
      if (fits) begin
         push_data.sum = shifted[SUM_W-1:0];
      end else begin
         push_data.sum = shifted[SHIFT_W-1] ? wna_pkg::SUM_MIN : wna_pkg::SUM_MAX;
      end
   end

   wna_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (s2_vld_ff),
      .push_data (push_data),
      .stat      (fifo_stat),
      .rsp_if    (rsp_if)
   );

   assign pos_ext = LEN_W'(pos_ff);

   a_end_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.end_vertex) |=> (s1_res_ff ##1 s2_vld_ff))
      else $error("end_vertex transaction did not release a drain element");

   a_last_idles_drain: assert property (@(posedge clock) disable iff (reset)
      (s1_res_ff && s1_last_ff) |-> (len_ff == '0))
      else $error("drain still pending after its last element");

   a_pos_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> (pos_ext < len_ff))
      else $error("drain position beyond drain length");

   a_queue_credit: assert property (@(posedge clock) disable iff (reset)
      credit_used <= CNT_W'(wna_pkg::FIFO_DEPTH))
      else $error("output queue over-committed");

endmodule

>>> bench/tb_top.sv
module tb_top;
   import wna_pkg::*;

   // Predictor sizing and handy fixed-point extremes
   localparam int NUM_ELEMS = MAX_FEAT_DIM_DEF;
   localparam logic signed [VALUE_W-1:0]  VAL_LO  = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0]  VAL_HI  = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [WEIGHT_W-1:0] WGT_LO  = {1'b1, {(WEIGHT_W-1){1'b0}}};
   localparam logic signed [WEIGHT_W-1:0] WGT_HI  = {1'b0, {(WEIGHT_W-1){1'b1}}};
   // 1.0 in Q2.14, the weight of a forward pass
   localparam logic signed [WEIGHT_W-1:0] WGT_ONE = 16'sd16384;
   localparam longint ACC_HI = longint'($signed(ACC_MAX));
   localparam longint ACC_LO = longint'($signed(ACC_MIN));
   localparam longint SUM_HI = longint'($signed(SUM_MAX));
   localparam longint SUM_LO = longint'($signed(SUM_MIN));
   // Output queue latency plus margin, used before every CSR write but the first, and at the end
   localparam int QUIET_CYCLES = 6;

   typedef struct packed {
      logic                        op;
      logic [IDX_OUT_W-1:0]        feat_index;
      logic signed [VALUE_W-1:0]   value;
      logic signed [WEIGHT_W-1:0]  weight;
      logic                        end_vertex;
   } elem_type;

   // One row of the directed stimulus; typed rows carry a hand-worked result
   typedef struct {
      elem_type e;
      bit       typed;
      rsp_type  want;
   } step_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [DIM_W-1:0]    csr_wdata;

   wna_req_if req_bus ();
   wna_rsp_if rsp_bus ();

   weighted_neighbor_aggregation uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus)
   );

   always #5 clock = ~clock;

   // Random phases: programmed feat_dim, sender idle %, receiver stall %, transactions.
   // 0 behaves as 1 and 127 as 64.
   int phase_dim   [6] = '{16, 0, 127, 5, 1, 23};
   int phase_idle  [6] = '{0, 73, 0, 25, 0, 73};
   int phase_stall [6] = '{0, 0, 73, 25, 0, 73};
   int phase_items [6] = '{40, 40, 40, 60, 40, 40};

   // Shadow of the aggregation state
   logic [DIM_W-1:0] dim_reg;
   longint           live_acc   [NUM_ELEMS];
   longint           drain_bank [NUM_ELEMS];
   bit               written    [NUM_ELEMS];
   int               drain_pos;
   int               drain_len;

   rsp_type          pending_sums [$];
   int               mismatches;
   int               items_sent;
   int               idle_pct;
   int               stall_pct;

   function automatic int active_dim();
      int d;
      d = int'(dim_reg);
      if (d == 0) d = 1;
      if (d > NUM_ELEMS) d = NUM_ELEMS;
      return d;
   endfunction

   // True once every element that a drain would read has been loaded since reset
   function automatic bit dim_ready();
      int d;
      d = active_dim();
      for (int k = 0; k < d; k++) begin
         if (!written[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Q18.30 -> Q8.16: add half an LSB, floor shift, then clip and flag
   function automatic rsp_type round_sum(longint acc, int pos, bit lst);
      longint  r;
      rsp_type o;
      r = (acc + longint'(ROUND_BIAS)) >>> FRAC_DROP;
      o.out_index = pos[IDX_OUT_W-1:0];
      o.last      = lst;
      o.saturated = (r > SUM_HI) || (r < SUM_LO);
      if (r > SUM_HI)      o.sum = SUM_MAX;
      else if (r < SUM_LO) o.sum = SUM_MIN;
      else                 o.sum = r[SUM_W-1:0];
      return o;
   endfunction

   // Apply one accepted transaction and return the drained element it releases, if any
   function automatic bit aggregate_element(input elem_type e, output rsp_type r);
      int     d;
      int     j;
      longint prod;
      longint acc;
      d    = active_dim();
      j    = int'(e.feat_index);
      prod = longint'($signed(e.value)) * longint'($signed(e.weight));
      r    = '0;
      // out-of-range index: leave the accumulators alone, but honour end_vertex
      if (j < d) begin
         if (e.op == OP_SELF) begin
            live_acc[j] = prod;
            written[j]  = 1'b1;
         end else begin
            acc = live_acc[j] + prod;
            if (acc > ACC_HI) acc = ACC_HI;
            if (acc < ACC_LO) acc = ACC_LO;
            live_acc[j] = acc;
         end
      end
      // end of vertex: snapshot and (re)start the drain, even mid-drain
      if (e.end_vertex) begin
         for (int k = 0; k < d; k++) drain_bank[k] = live_acc[k];
         drain_len = d;
         drain_pos = 0;
      end
      if (drain_pos >= drain_len) return 1'b0;
      r = round_sum(drain_bank[drain_pos], drain_pos, drain_pos + 1 == drain_len);
      drain_pos++;
      if (drain_pos >= drain_len) begin
         drain_pos = 0;
         drain_len = 0;
      end
      return 1'b1;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return VAL_LO;
         1:       return VAL_HI;
         2:       return '0;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(7))
         0:       return WGT_LO;
         1:       return WGT_HI;
         2:       return WGT_ONE;
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   function automatic elem_type make_elem(logic op, int j, logic signed [VALUE_W-1:0] v,
                                          logic signed [WEIGHT_W-1:0] w, logic endv);
      elem_type e;
      e.op         = op;
      e.feat_index = j[IDX_OUT_W-1:0];
      e.value      = v;
      e.weight     = w;
      e.end_vertex = endv;
      return e;
   endfunction

   function automatic step_row_type drow(logic op, int j, int v, int w, logic endv,
                                         bit typed = 1'b0, int oi = 0, int s = 0,
                                         logic sat = 1'b0, logic lst = 1'b0);
      step_row_type r;
      r.e               = make_elem(op, j, v[VALUE_W-1:0], w[WEIGHT_W-1:0], endv);
      r.typed           = typed;
      r.want.out_index  = oi[IDX_OUT_W-1:0];
      r.want.sum        = s[SUM_W-1:0];
      r.want.saturated  = sat;
      r.want.last       = lst;
      return r;
   endfunction

   // Offer one transaction, hold it until accepted, then book the expected result.
   // Entered and left just after a rising edge, so valid stays high back to back.
   task automatic send(input elem_type e, input bit typed, input rsp_type want);
      rsp_type got;
      bit      has;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= e.op;
      req_bus.feat_index <= e.feat_index;
      req_bus.value      <= e.value;
      req_bus.weight     <= e.weight;
      req_bus.end_vertex <= e.end_vertex;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      has = aggregate_element(e, got);
      if (has) pending_sums.push_back(typed ? want : got);
      items_sent++;
   endtask

   task automatic send_plain(input elem_type e);
      send(e, 1'b0, '0);
   endtask

   // Drop valid, wait for every booked result, then let the pipeline go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic set_feat_dim(input int v);
      csr_we    <= 1'b1;
      csr_wdata <= v[DIM_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      dim_reg    = v[DIM_W-1:0];
   endtask

   // A well-formed vertex: every self element in shuffled order, a random batch of
   // neighbour contributions, end_vertex on the closing transaction
   task automatic stream_vertex();
      int                          d;
      int                          links;
      int                          total;
      int                          m;
      int                          tmp;
      int                          order [NUM_ELEMS];
      logic signed [WEIGHT_W-1:0]  norm;
      elem_type                    e;
      d = active_dim();
      for (int k = 0; k < d; k++) order[k] = k;
      for (int k = d - 1; k > 0; k--) begin
         m        = $urandom_range(k);
         tmp      = order[k];
         order[k] = order[m];
         order[m] = tmp;
      end
      // forward pass: unit weight; backward pass: the vertex norm factor
      norm  = $urandom_range(1) ? WGT_ONE : pick_weight();
      links = $urandom_range(d);
      total = d + links;
      for (int k = 0; k < total; k++) begin
         if (k < d)
            e = make_elem(OP_SELF, order[k], pick_value(), norm, k == total - 1);
         else
            e = make_elem(OP_EDGE, $urandom_range(d - 1), pick_value(), pick_weight(),
                          k == total - 1);
         send_plain(e);
      end
   endtask

   // Loose transaction: any index, any op, stray end flags; never reads an
   // accumulator that has not been loaded since reset
   task automatic send_noise();
      elem_type e;
      int       j;
      j = $urandom_range(NUM_ELEMS - 1);
      e = make_elem($urandom_range(1) ? OP_EDGE : OP_SELF, j, pick_value(), pick_weight(),
                    $urandom_range(7) == 0);
      if (e.op == OP_EDGE && j < active_dim() && !written[j]) e.op = OP_SELF;
      if (e.end_vertex && !dim_ready()) e.end_vertex = 1'b0;
      send_plain(e);
   endtask

   // Feed harmless self loads until the current drain has run out
   task automatic flush_drain();
      while (drain_len != 0)
         send_plain(make_elem(OP_SELF, $urandom_range(NUM_ELEMS - 1), pick_value(),
                              pick_weight(), 1'b0));
   endtask

   // Receiver: stall at the phase's rate, hold low during reset
   initial begin : receiver
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each accepted result with the oldest booked one, field by field
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_sums.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: unexpected result idx=%0d sum=%0d sat=%0b last=%0b",
                        rsp_bus.out_index, rsp_bus.sum, rsp_bus.saturated, rsp_bus.last);
            mismatches++;
         end else begin
            want = pending_sums.pop_front();
            if (rsp_bus.out_index !== want.out_index || rsp_bus.sum !== want.sum ||
                rsp_bus.saturated !== want.saturated || rsp_bus.last !== want.last) begin
               if (mismatches < 10) begin
                  $display("ERROR: result mismatch: expected idx=%0d sum=%0d sat=%0b last=%0b",
                           want.out_index, want.sum, want.saturated, want.last);
                  $display("       got idx=%0d sum=%0d sat=%0b last=%0b",
                           rsp_bus.out_index, rsp_bus.sum, rsp_bus.saturated, rsp_bus.last);
               end
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      step_row_type rows [$];
      int           start;

      dim_reg    = FEAT_DIM_RST;
      drain_pos  = 0;
      drain_len  = 0;
      mismatches = 0;
      items_sent = 0;
      idle_pct   = 0;
      stall_pct  = 0;
      foreach (written[k]) begin
         written[k]    = 1'b0;
         live_acc[k]   = 0;
         drain_bank[k] = 0;
      end

      // Known levels on every input before the first edge
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.op         <= OP_SELF;
      req_bus.feat_index <= '0;
      req_bus.value      <= '0;
      req_bus.weight     <= '0;
      req_bus.end_vertex <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at feat_dim 2: rounding edges, clipping, out-of-range index,
      // restart of a drain by a second end_vertex
      set_feat_dim(2);
      rows.push_back(drow(OP_SELF, 0, 65536, 16384, 1'b0));           // 1.0 * 1.0
      rows.push_back(drow(OP_SELF, 1, -8388608, -32768, 1'b0));       // most positive product
      rows.push_back(drow(OP_EDGE, 63, 8388607, 32767, 1'b0));        // index out of range
      rows.push_back(drow(OP_EDGE, 0, 0, 0, 1'b1, 1'b1, 0, 65536, 1'b0, 1'b0));
      rows.push_back(drow(OP_SELF, 0, 8388607, 32767, 1'b0,
                          1'b1, 1, 8388607, 1'b1, 1'b1));
      rows.push_back(drow(OP_SELF, 1, -8388608, 32767, 1'b0));
      // out-of-range index still closes the vertex
      rows.push_back(drow(OP_EDGE, 3, 12345, -777, 1'b1, 1'b1, 0, 8388607, 1'b1, 1'b0));
      // second end mid-drain: restart from element 0
      rows.push_back(drow(OP_SELF, 0, 0, 0, 1'b1, 1'b1, 0, 0, 1'b0, 1'b0));
      rows.push_back(drow(OP_SELF, 0, 1, 1, 1'b0, 1'b1, 1, -8388608, 1'b1, 1'b1));
      // half-LSB rounding either side of zero
      rows.push_back(drow(OP_SELF, 0, 8192, 1, 1'b0));
      rows.push_back(drow(OP_SELF, 1, -8193, 1, 1'b1, 1'b1, 0, 1, 1'b0, 1'b0));
      rows.push_back(drow(OP_EDGE, 0, -1, 1, 1'b0, 1'b1, 1, -1, 1'b0, 1'b1));
      rows.push_back(drow(OP_SELF, 1, -8192, 1, 1'b1, 1'b1, 0, 0, 1'b0, 1'b0));
      rows.push_back(drow(OP_EDGE, 1, 0, 32767, 1'b0, 1'b1, 1, 0, 1'b0, 1'b1));
      rows.push_back(drow(OP_EDGE, 0, 8388607, -32768, 1'b0));
      rows.push_back(drow(OP_EDGE, 1, -8388608, 32767, 1'b1));
      rows.push_back(drow(OP_SELF, 1, 12345, -16384, 1'b0));
      foreach (rows[k]) send(rows[k].e, rows[k].typed, rows[k].want);
      flush_drain();
      settle();

      // Random phases: mostly complete vertices; one pick in four is a loose transaction
      for (int p = 0; p < 6; p++) begin
         set_feat_dim(phase_dim[p]);
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         start     = items_sent;
         while (items_sent - start < phase_items[p]) begin
            if ($urandom_range(3) == 0) send_noise();
            else                        stream_vertex();
         end
         flush_drain();
         settle();
      end

      if (mismatches == 0 && pending_sums.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin : watchdog
      #3000000;
      $display("Verification failed");
      $finish;
   end

endmodule
